[hdl/mean_square_level_hysteresis_defines.svh]
// Assertion macros shared by the mean-square level detector files.
`ifndef MEAN_SQUARE_LEVEL_HYSTERESIS_DEFINES_SVH
`define MEAN_SQUARE_LEVEL_HYSTERESIS_DEFINES_SVH

`ifndef SYNTHESIS

`define MSL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define MSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `MSL_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`else

`define MSL_ASSERT(lbl, clk, rstn, prop, msg)

`define MSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hdl/msl_pkg.sv]
// Types and constants of the mean-square level detector.
package msl_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SQ_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [SQ_W-1:0] SQ_MAX = 24'd16769025;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'd1;

    localparam logic [SQ_W-1:0] UPPER_RESET = SQ_MAX;
    localparam logic [SQ_W-1:0] LOWER_RESET = 24'd0;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic            level_high;
        logic [SQ_W-1:0] mean_square;
        logic [SQ_W-1:0] last_square;
    } t_out_res;

    typedef struct packed {
        logic [SQ_W-1:0] upper;
        logic [SQ_W-1:0] lower;
    } t_thresh;

endpackage

[hdl/msl_stream_if.sv]
// Valid/ready stream channel carrying one request or result per handshake.
interface msl_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/msl_cell.sv]
// One cell of the square shift line: holds one stored square.
module msl_cell #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

[hdl/msl_ring.sv]
// Squarer, chain of square cells and running sum of the window.
`include "mean_square_level_hysteresis_defines.svh"

module msl_ring #(
    parameter int DEPTH = 16,
    parameter int SUM_W = 28
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [msl_pkg::SAMPLE_W-1:0] i_sample,
    output logic [SUM_W-1:0]            o_sum,
    output logic [msl_pkg::SQ_W-1:0]    o_last
);
    import msl_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(longint'(DEPTH) * longint'(SQ_MAX));

    logic [2*SAMPLE_W-1:0] w_prod;
    logic [SQ_W-1:0]       w_sq;
    logic [SQ_W-1:0]       w_tap [DEPTH];
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic [SQ_W-1:0]       r_last;

    assign w_prod = {{SAMPLE_W{1'b0}}, i_sample} * {{SAMPLE_W{1'b0}}, i_sample};
    assign w_sq   = SQ_W'(w_prod);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            msl_cell #(.W(SQ_W)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(i_shift),
                .i_d    (w_sq),
                .o_q    (w_tap[g])
            );
        end else begin : g_body
            msl_cell #(.W(SQ_W)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(i_shift),
                .i_d    (w_tap[g-1]),
                .o_q    (w_tap[g])
            );
        end
    end

    // oldest square drops off the tail as the new one enters the head
    assign n_sum = r_sum - SUM_W'(w_tap[DEPTH-1]) + SUM_W'(w_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_shift) begin
            r_sum  <= n_sum;
            r_last <= w_sq;
        end
    end

    assign o_sum  = r_sum;
    assign o_last = r_last;

    `MSL_ASSERT(a_sum_range, i_clk, i_rst_n, r_sum <= SUM_MAX, "running sum out of range")
endmodule

[hdl/msl_report.sv]
// Report pipeline: mean by reciprocal divide, hysteresis flag, result register.
`include "mean_square_level_hysteresis_defines.svh"

module msl_report #(
    parameter int DEPTH = 16,
    parameter int SUM_W = 28
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [SUM_W-1:0]         i_sum,
    input  logic [msl_pkg::SQ_W-1:0] i_last,
    input  msl_pkg::t_thresh         i_thr,
    output logic                     o_ready,
    msl_stream_if.source             o_res
);
    import msl_pkg::*;

    // floor(2^SUM_W / DEPTH): estimate is exact or one low
    localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    logic w_ofree, w_mv3, w_free3, w_free2, w_free1;

    logic             r_v1;
    logic [SUM_W-1:0] r_s1_sum;
    logic [SQ_W-1:0]  r_s1_last;

    logic [2*SUM_W-1:0] w_prod;
    logic               r_v2;
    logic [SQ_W-1:0]    r_s2_qest;
    logic [SUM_W-1:0]   r_s2_sum;
    logic [SQ_W-1:0]    r_s2_last;

    logic [SUM_W-1:0] w_back;
    logic [SUM_W-1:0] w_rem;
    logic [SQ_W-1:0]  w_q;
    logic             r_v3;
    logic [SQ_W-1:0]  r_s3_mean;
    logic [SQ_W-1:0]  r_s3_last;

    logic            r_ov;
    logic            r_flag;
    logic            n_flag;
    logic [SQ_W-1:0] r_out_mean;
    logic [SQ_W-1:0] r_out_last;
    t_out_res        w_res;

    assign w_ofree = !r_ov || o_res.ready;
    assign w_mv3   = r_v3 && w_ofree;
    assign w_free3 = !r_v3 || w_ofree;
    assign w_free2 = !r_v2 || w_free3;
    assign w_free1 = !r_v1 || w_free2;
    assign o_ready = w_free1;

    assign w_prod = {{SUM_W{1'b0}}, r_s1_sum} * {{SUM_W{1'b0}}, RECIP};

    assign w_back = SUM_W'(SUM_W'(r_s2_qest) * DEPTH_S);
    assign w_rem  = r_s2_sum - w_back;
    assign w_q    = r_s2_qest + SQ_W'(w_rem >= DEPTH_S);

    // set wins over clear when the thresholds overlap
    always_comb begin
        n_flag = r_flag;
        if (r_s3_mean >= i_thr.upper) begin
            n_flag = 1'b1;
        end else if (r_s3_mean <= i_thr.lower) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_ov   <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            r_v1 <= i_take || (r_v1 && !w_free2);
            r_v2 <= (r_v1 && w_free2) || (r_v2 && !w_free3);
            r_v3 <= (r_v2 && w_free3) || (r_v3 && !w_ofree);
            r_ov <= w_mv3 || (r_ov && !o_res.ready);
            if (w_mv3) begin
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1_sum  <= i_sum;
            r_s1_last <= i_last;
        end
        if (r_v1 && w_free2) begin
            r_s2_qest <= w_prod[SUM_W +: SQ_W];
            r_s2_sum  <= r_s1_sum;
            r_s2_last <= r_s1_last;
        end
        if (r_v2 && w_free3) begin
            r_s3_mean <= w_q;
            r_s3_last <= r_s2_last;
        end
        if (w_mv3) begin
            r_out_mean <= r_s3_mean;
            r_out_last <= r_s3_last;
        end
    end

    always_comb begin
        w_res.level_high  = r_flag;
        w_res.mean_square = r_out_mean;
        w_res.last_square = r_out_last;
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = w_res;

    `MSL_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_v2, w_rem < (DEPTH_S << 1), "quotient estimate off by more than one")
    `MSL_ASSERT_IMPL(a_take_free, i_clk, i_rst_n, i_take, w_free1, "request taken into a full stage")
    `MSL_ASSERT_IMPL(a_flag_load, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_flag), $past(w_mv3), "flag changed without a result load")
endmodule

[hdl/mean_square_level_hysteresis.sv]
// Sample request: no result; the squarer and the cell chain take one per cycle while the input is ready.
// Report request: captured at acceptance, then reciprocal multiply, correction, hysteresis and
//   result register; one request per cycle sustained while the output accepts results.
// Input stalls only when all four report stages hold unaccepted work.
// Synchronous active-low reset clears the cells, running sum, last square, flag and
//   stage valids at once; thresholds return to full scale (upper) and zero (lower).
module mean_square_level_hysteresis #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [msl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [msl_pkg::SQ_W-1:0]      i_cfg_data,
    msl_stream_if.sink                    i_in,
    msl_stream_if.source                  o_out
);
    import msl_pkg::*;

    localparam int SUM_W = $clog2(longint'(RING_DEPTH) * longint'(SQ_MAX) + 1);

    logic [SQ_W-1:0] r_upper_thr;
    logic [SQ_W-1:0] r_lower_thr;
    t_thresh         w_thr;
    t_in_req         w_req;
    logic            w_acc;
    logic            w_shift;
    logic            w_take;
    logic            w_ready;
    logic [SUM_W-1:0] w_sum;
    logic [SQ_W-1:0]  w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_thr <= UPPER_RESET;
            r_lower_thr <= LOWER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER: r_upper_thr <= i_cfg_data;
                CFG_LOWER: r_lower_thr <= i_cfg_data;
            endcase
        end
    end

    assign w_thr.upper = r_upper_thr;
    assign w_thr.lower = r_lower_thr;

    assign w_req      = i_in.data;
    assign i_in.ready = w_ready;
    assign w_acc      = i_in.valid && w_ready;
    assign w_shift    = w_acc && (w_req.command == CMD_SAMPLE);
    assign w_take     = w_acc && (w_req.command == CMD_REPORT);

    msl_ring #(
        .DEPTH(RING_DEPTH),
        .SUM_W(SUM_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_sample(w_req.sample),
        .o_sum   (w_sum),
        .o_last  (w_last)
    );

    msl_report #(
        .DEPTH(RING_DEPTH),
        .SUM_W(SUM_W)
    ) u_report (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_sum  (w_sum),
        .i_last (w_last),
        .i_thr  (w_thr),
        .o_ready(w_ready),
        .o_res  (o_out)
    );
endmodule
